FILE: hdl/gccs_pkg.sv
// Package for the grouped command collector: field widths, opcodes,
// configuration register indexes and the queue entry type.
// No dependencies.
package gccs_pkg;

    localparam int DATA_W    = 16;
    localparam int MASK_W    = 12;
    localparam int LIMIT_W   = 15;
    localparam int LIMIT_CNT = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;
    localparam int MAX_SLOTS = 8;
    localparam int OUT_SLOTS = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd16384;

    // opcodes
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_ZERO  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2 = 3'd4;

    typedef enum logic [1:0] {
        K_NOP,
        K_SET,
        K_FLUSH,
        K_ZERO
    } t_kind;

    // classified transaction handed from the front to the back
    typedef struct packed {
        t_kind                 kind;
        logic                  status;
        logic [1:0]            grp;
        logic [1:0]            slot;
        logic [DATA_W-1:0]     value;
        logic [MAX_SLOTS-1:0]  members;
    } t_cmd;

endpackage

FILE: hdl/gccs_cmd_if.sv
// Input channel interface of the grouped command collector.
// Depends on gccs_pkg.
interface gccs_cmd_if
    import gccs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [1:0]                group_index;
    logic [1:0]                slot_index;
    logic signed [DATA_W-1:0]  command_value;

    modport source (output valid, output opcode, output group_index,
                    output slot_index, output command_value, input ready);
    modport sink   (input valid, input opcode, input group_index,
                    input slot_index, input command_value, output ready);
endinterface

FILE: hdl/gccs_rsp_if.sv
// Result channel interface of the grouped command collector.
// Depends on gccs_pkg.
interface gccs_rsp_if
    import gccs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic                      frame_sent;
    logic [1:0]                frame_group;
    logic signed [DATA_W-1:0]  slot0_command;
    logic signed [DATA_W-1:0]  slot1_command;
    logic signed [DATA_W-1:0]  slot2_command;
    logic signed [DATA_W-1:0]  slot3_command;

    modport source (output valid, output status, output frame_sent,
                    output frame_group, output slot0_command, output slot1_command,
                    output slot2_command, output slot3_command, input ready);
    modport sink   (input valid, input status, input frame_sent,
                    input frame_group, input slot0_command, input slot1_command,
                    input slot2_command, input slot3_command, output ready);
endinterface

FILE: hdl/grouped_command_collect_and_send.sv
// Top level of the grouped command collector: front decode, queue, back end.
// Depends on gccs_pkg, gccs_cmd_if, gccs_rsp_if, gccs_front, gccs_fifo, gccs_back.
//
//   port      dir  kind            contents
//   i_cmd     in   valid/ready     opcode, group_index, slot_index, command_value
//   o_rsp     out  valid/ready     status, frame_sent, frame_group, slot0..3_command
//   i_cfg_*   in   write strobe    register index, write data
//
// One transaction per cycle sustained while the output is not stalled; a result is
// written into the queue when its input is accepted and loaded from there into
// the output register by the back end. Each item reads and rewrites its group's slot
// row and pending bits in the same cycle in the back end, so consecutive items to the
// same group follow without gaps. Synchronous reset restores register defaults
// and clears slot values and pending bits. A stalled output fills the two-entry
// queue, after which i_cmd.ready drops.
module grouped_command_collect_and_send
    import gccs_pkg::*;
#(
    parameter int SLOTS_PER_GROUP = 4,
    parameter int GROUP_COUNT     = 3,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    gccs_cmd_if.sink              i_cmd,
    gccs_rsp_if.source            o_rsp
);

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_cmd  q_in;
    t_cmd  q_out;

    gccs_front #(
        .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
        .GROUP_COUNT     (GROUP_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    gccs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gccs_back #(
        .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
        .GROUP_COUNT     (GROUP_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_pop_held_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !q_pop)
        else $error("result overwritten while stalled");

    a_err_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> !o_rsp.frame_sent)
        else $error("frame sent with error status");

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.frame_sent) |->
            (o_rsp.frame_group == 2'd0 && o_rsp.slot0_command == '0 &&
             o_rsp.slot1_command == '0 && o_rsp.slot2_command == '0 &&
             o_rsp.slot3_command == '0))
        else $error("frame fields nonzero without a frame");

endmodule

FILE: hdl/gccs_front.sv
// Front end: configuration registers, input decode, membership checks and
// clamp/reverse of set commands. Depends on gccs_pkg, gccs_cmd_if.
module gccs_front
    import gccs_pkg::*;
#(
    parameter int SLOTS_PER_GROUP = 4,
    parameter int GROUP_COUNT     = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    gccs_cmd_if.sink              i_cmd,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_data
);

    logic [MASK_W-1:0]  r_member;
    logic [MASK_W-1:0]  r_rev;
    logic [LIMIT_W-1:0] r_lim [LIMIT_CNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_rev    <= '0;
            for (int i = 0; i < LIMIT_CNT; i++) begin
                r_lim[i] <= LIMIT_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEMBER:  r_member <= i_cfg_wdata[MASK_W-1:0];
                CFG_REVERSE: r_rev    <= i_cfg_wdata[MASK_W-1:0];
                CFG_LIMIT0:  r_lim[0] <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_LIMIT1:  r_lim[1] <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_LIMIT2:  r_lim[2] <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cmd.ready = !i_q_full;
    assign o_q_push    = i_cmd.valid && !i_q_full;

    logic [4:0]               bit_base;
    logic [MASK_W-1:0]        mem_sh;
    logic [MASK_W-1:0]        rev_sh;
    logic [MAX_SLOTS-1:0]     members;
    logic                     grp_ok;
    logic                     slot_ok;
    logic                     mem_hit;
    logic                     rev_hit;
    logic [LIMIT_W-1:0]       lim;
    logic signed [DATA_W:0]   v_ext;
    logic signed [DATA_W:0]   lim_p;
    logic signed [DATA_W:0]   lim_n;
    logic signed [DATA_W:0]   v_clamp;
    logic signed [DATA_W:0]   v_phys;

    always_comb begin
        bit_base = 5'(int'(i_cmd.group_index) * SLOTS_PER_GROUP);
        mem_sh   = r_member >> bit_base;
        rev_sh   = r_rev >> bit_base;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            members[k] = (k < SLOTS_PER_GROUP) ? mem_sh[k] : 1'b0;
        end
        grp_ok  = int'(i_cmd.group_index) < GROUP_COUNT;
        slot_ok = int'(i_cmd.slot_index) < SLOTS_PER_GROUP;
        mem_hit = |(members & (MAX_SLOTS'(1) << i_cmd.slot_index));
        rev_hit = |(rev_sh & (MASK_W'(1) << i_cmd.slot_index));

        // groups beyond the limit registers keep the reset clamp
        lim = (int'(i_cmd.group_index) < LIMIT_CNT) ? r_lim[i_cmd.group_index]
                                                    : LIMIT_RST;
        v_ext = (DATA_W+1)'(i_cmd.command_value);
        lim_p = signed'({2'b00, lim});
        lim_n = -lim_p;
        if (v_ext > lim_p) begin
            v_clamp = lim_p;
        end else if (v_ext < lim_n) begin
            v_clamp = lim_n;
        end else begin
            v_clamp = v_ext;
        end
        v_phys = rev_hit ? -v_clamp : v_clamp;

        o_q_data.grp     = i_cmd.group_index;
        o_q_data.slot    = i_cmd.slot_index;
        o_q_data.value   = v_phys[DATA_W-1:0];
        o_q_data.members = members;
        o_q_data.kind    = K_NOP;
        o_q_data.status  = 1'b0;
        case (i_cmd.opcode)
            OP_SET: begin
                if (grp_ok && slot_ok && mem_hit) begin
                    o_q_data.kind = K_SET;
                end else begin
                    o_q_data.status = 1'b1;
                end
            end
            OP_FLUSH, OP_ZERO: begin
                if (grp_ok && (members != '0)) begin
                    o_q_data.kind = (i_cmd.opcode == OP_ZERO) ? K_ZERO : K_FLUSH;
                end else begin
                    o_q_data.status = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/gccs_fifo.sv
// Short queue between front and back, registered entries.
// Depends on gccs_pkg.
module gccs_fifo
    import gccs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_data,
    input  logic  i_pop,
    output t_cmd  o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/gccs_back.sv
// Back end: slot buffer and pending bits per group, frame assembly and the
// result output register. Depends on gccs_pkg, gccs_rsp_if.
module gccs_back
    import gccs_pkg::*;
#(
    parameter int SLOTS_PER_GROUP = 4,
    parameter int GROUP_COUNT     = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_q_data,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    gccs_rsp_if.source  o_rsp
);

    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int SW = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;

    typedef logic [SLOTS_PER_GROUP-1:0][DATA_W-1:0] t_row;

    t_row                        r_row  [GROUP_COUNT];
    logic [SLOTS_PER_GROUP-1:0]  r_pend [GROUP_COUNT];

    logic                        r_valid;
    logic                        r_status;
    logic                        r_sent;
    logic [1:0]                  r_group;
    logic [DATA_W-1:0]           r_slot [OUT_SLOTS];

    logic [GW-1:0]               g_idx;
    logic [SW-1:0]               s_idx;
    t_row                        row;
    t_row                        n_row;
    logic [SLOTS_PER_GROUP-1:0]  pend;
    logic [SLOTS_PER_GROUP-1:0]  n_pend;
    logic                        send;
    logic                        wr;
    logic [DATA_W-1:0]           slot_v [OUT_SLOTS];

    // output register frees up when empty or taken this cycle
    assign o_q_pop = !i_q_empty && (!r_valid || o_rsp.ready);

    always_comb begin
        g_idx  = GW'(i_q_data.grp);
        s_idx  = SW'(i_q_data.slot);
        row    = r_row[g_idx];
        pend   = r_pend[g_idx];
        n_row  = row;
        n_pend = pend;
        send   = 1'b0;
        wr     = 1'b0;
        case (i_q_data.kind)
            K_SET: begin
                wr            = 1'b1;
                n_row[s_idx]  = i_q_data.value;
                n_pend        = pend | (SLOTS_PER_GROUP'(1) << i_q_data.slot);
                send          = (n_pend == i_q_data.members[SLOTS_PER_GROUP-1:0]);
                if (send) begin
                    n_pend = '0;
                end
            end
            K_FLUSH: begin
                wr     = 1'b1;
                send   = 1'b1;
                n_pend = '0;
            end
            K_ZERO: begin
                wr     = 1'b1;
                send   = 1'b1;
                n_row  = '0;
                n_pend = '0;
            end
            default: ;
        endcase
    end

    for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_out
        if (k < SLOTS_PER_GROUP) begin : g_have
            assign slot_v[k] = send ? n_row[k] : '0;
        end else begin : g_none
            assign slot_v[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
                r_row[i]  <= '0;
                r_pend[i] <= '0;
            end
        end else if (o_q_pop && wr) begin
            r_row[g_idx]  <= n_row;
            r_pend[g_idx] <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= i_q_data.status;
            r_sent   <= send;
            r_group  <= send ? i_q_data.grp : 2'd0;
            for (int k = 0; k < OUT_SLOTS; k++) begin
                r_slot[k] <= slot_v[k];
            end
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.frame_sent    = r_sent;
    assign o_rsp.frame_group   = r_group;
    assign o_rsp.slot0_command = r_slot[0];
    assign o_rsp.slot1_command = r_slot[1];
    assign o_rsp.slot2_command = r_slot[2];
    assign o_rsp.slot3_command = r_slot[3];

endmodule

FILE: bench/grouped_command_collect_and_send_test.sv
// Self-checking bench for grouped_command_collect_and_send: directed table, then random phases.
// Frames are predicted per accepted transaction and checked in order on the result channel.
// Depends on gccs_pkg, gccs_cmd_if, gccs_rsp_if and the block itself.
`timescale 1ns / 1ps

module grouped_command_collect_and_send_test;
    import gccs_pkg::*;

    localparam int GROUPS      = 3;
    localparam int SLOTS       = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [1:0]              grp;
        logic [1:0]              slot;
        logic signed [DATA_W-1:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic                                status;
        logic                                sent;
        logic [1:0]                          grp;
        logic [OUT_SLOTS-1:0][DATA_W-1:0]    slot_cmd;
    } t_frame;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_W-1:0]      cfg_data;
        t_cmd_item             item;
        bit                    fixed;
        t_frame                want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    gccs_cmd_if cmd_bus ();
    gccs_rsp_if rsp_bus ();

    grouped_command_collect_and_send i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_rsp       (rsp_bus)
    );

    // predictor state
    logic [MASK_W-1:0]  member_cfg;
    logic [MASK_W-1:0]  reverse_cfg;
    logic [LIMIT_W-1:0] clamp_limit [GROUPS];
    logic [DATA_W-1:0]  slot_store [GROUPS*SLOTS];
    logic [SLOTS-1:0]   waiting_bits [GROUPS];

    t_frame   frames_due [$];
    t_dir_row dir_rows [$];
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_frame mk_frame(input bit st, input bit snt, input int g,
                                        input int c0, input int c1, input int c2, input int c3);
        t_frame r;
        r.status      = st;
        r.sent        = snt;
        r.grp         = g[1:0];
        r.slot_cmd[0] = c0[15:0];
        r.slot_cmd[1] = c1[15:0];
        r.slot_cmd[2] = c2[15:0];
        r.slot_cmd[3] = c3[15:0];
        return r;
    endfunction

    function automatic t_frame emit_group(input int g);
        t_frame r;
        r      = '0;
        r.sent = 1'b1;
        r.grp  = g[1:0];
        for (int s = 0; s < SLOTS; s++) r.slot_cmd[s] = slot_store[g*SLOTS+s];
        waiting_bits[g] = '0;
        return r;
    endfunction

    function automatic t_frame predict_frame(input t_cmd_item c);
        t_frame r;
        logic [SLOTS-1:0] members;
        int g;
        int v;
        int lim;
        int pos;
        r = '0;
        g = c.grp;
        if (c.opcode == OP_NONE) return r;
        if (g >= GROUPS) begin
            r.status = 1'b1;
            return r;
        end
        members = member_cfg[g*SLOTS +: SLOTS];
        if (c.opcode == OP_SET) begin
            if (!members[c.slot]) begin
                r.status = 1'b1;
                return r;
            end
            v   = $signed(c.value);
            lim = clamp_limit[g];
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            pos = g*SLOTS + c.slot;
            if (reverse_cfg[pos]) v = -v;
            slot_store[pos] = v[15:0];
            waiting_bits[g][c.slot] = 1'b1;
            // stale pending bits of dropped members block the automatic send
            if (waiting_bits[g] == members) r = emit_group(g);
            return r;
        end
        if (members == '0) begin
            r.status = 1'b1;
            return r;
        end
        if (c.opcode == OP_ZERO) begin
            for (int s = 0; s < SLOTS; s++) slot_store[g*SLOTS+s] = '0;
        end
        r = emit_group(g);
        return r;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            CFG_MEMBER:  member_cfg     = data[MASK_W-1:0];
            CFG_REVERSE: reverse_cfg    = data[MASK_W-1:0];
            CFG_LIMIT0:  clamp_limit[0] = data[LIMIT_W-1:0];
            CFG_LIMIT1:  clamp_limit[1] = data[LIMIT_W-1:0];
            CFG_LIMIT2:  clamp_limit[2] = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_cmd_item mk_cmd(input logic [1:0] op, input int g, input int s,
                                         input int v);
        t_cmd_item c;
        c.opcode = op;
        c.grp    = g[1:0];
        c.slot   = s[1:0];
        c.value  = v[15:0];
        return c;
    endfunction

    function automatic t_dir_row row_cmd(input logic [1:0] op, input int g, input int s,
                                         input int v);
        t_dir_row r;
        r.is_cfg   = 1'b0;
        r.cfg_idx  = '0;
        r.cfg_data = '0;
        r.item     = mk_cmd(op, g, s, v);
        r.fixed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic t_dir_row row_typed(input logic [1:0] op, input int g, input int s,
                                           input int v, input t_frame want);
        t_dir_row r;
        r       = row_cmd(op, g, s, v);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_dir_row r;
        r          = row_cmd(OP_NONE, 0, 0, 0);
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data[CFG_W-1:0];
        return r;
    endfunction

    function automatic t_cmd_item random_item();
        t_cmd_item c;
        logic [SLOTS-1:0] members;
        int pick;
        int g;
        int s;
        int v;
        pick = $urandom_range(99);
        g    = $urandom_range(GROUPS-1);
        s    = $urandom_range(SLOTS-1);
        case ($urandom_range(7))
            0:       v = 32767;
            1:       v = -32768;
            2:       v = 0;
            3:       v = -1;
            default: v = $urandom_range(65535);
        endcase
        members = member_cfg[g*SLOTS +: SLOTS];
        if (pick < 72) begin
            if (members != '0) begin
                while (!members[s]) s = $urandom_range(SLOTS-1);
            end
            c = mk_cmd(OP_SET, g, s, v);
        end else if (pick < 82) begin
            c = mk_cmd(OP_FLUSH, g, s, v);
        end else if (pick < 88) begin
            c = mk_cmd(OP_ZERO, g, s, v);
        end else begin
            c = mk_cmd(2'($urandom_range(3)), $urandom_range(3), s, v);
        end
        return c;
    endfunction

    task automatic send_cmd(input t_cmd_item c, input bit fixed, input t_frame want);
        t_frame pred;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.opcode        <= c.opcode;
        cmd_bus.group_index   <= c.grp;
        cmd_bus.slot_index    <= c.slot;
        cmd_bus.command_value <= c.value;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        pred = predict_frame(c);
        frames_due.push_back(fixed ? want : pred);
    endtask

    // sender goes quiet until every outstanding frame has been checked
    task automatic settle_pipeline();
        cmd_bus.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        apply_cfg(idx, data);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_frame due;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (frames_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t result expected none actual status %b sent %b group %0d",
                             $time, rsp_bus.status, rsp_bus.frame_sent, rsp_bus.frame_group);
            end else begin
                due = frames_due.pop_front();
                check_field("status", 16'(due.status), 16'(rsp_bus.status));
                check_field("frame_sent", 16'(due.sent), 16'(rsp_bus.frame_sent));
                check_field("frame_group", 16'(due.grp), 16'(rsp_bus.frame_group));
                check_field("slot0_command", due.slot_cmd[0], rsp_bus.slot0_command);
                check_field("slot1_command", due.slot_cmd[1], rsp_bus.slot1_command);
                check_field("slot2_command", due.slot_cmd[2], rsp_bus.slot2_command);
                check_field("slot3_command", due.slot_cmd[3], rsp_bus.slot3_command);
            end
        end
    end

    initial begin : main_seq
        t_frame no_frame;
        t_frame miss_frame;
        int n_items;
        int lim_pick;

        no_frame   = '0;
        miss_frame = mk_frame(1'b1, 1'b0, 0, 0, 0, 0, 0);

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_wdata           = '0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.opcode        = OP_SET;
        cmd_bus.group_index   = '0;
        cmd_bus.slot_index    = '0;
        cmd_bus.command_value = '0;
        rsp_bus.ready         = 1'b0;

        member_cfg  = '0;
        reverse_cfg = '0;
        for (int g = 0; g < GROUPS; g++) begin
            clamp_limit[g]  = LIMIT_RST;
            waiting_bits[g] = '0;
        end
        for (int k = 0; k < GROUPS*SLOTS; k++) slot_store[k] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no members after reset: everything but the unused opcode is not-found
        dir_rows.push_back(row_typed(OP_SET, 0, 0, 100, miss_frame));
        dir_rows.push_back(row_typed(OP_FLUSH, 1, 0, 0, miss_frame));
        dir_rows.push_back(row_typed(OP_ZERO, 2, 0, 0, miss_frame));
        dir_rows.push_back(row_typed(OP_NONE, 1, 2, 16'h5a5a, no_frame));
        dir_rows.push_back(row_typed(OP_SET, 3, 1, -5, miss_frame));
        dir_rows.push_back(row_typed(OP_FLUSH, 3, 0, 0, miss_frame));
        dir_rows.push_back(row_cfg(CFG_MEMBER, 12'hFFF));
        dir_rows.push_back(row_cfg(CFG_REVERSE, 12'h0F0));
        // clamp at the reset limit, frame on the fourth slot
        dir_rows.push_back(row_typed(OP_SET, 0, 0, 32767, no_frame));
        dir_rows.push_back(row_typed(OP_SET, 0, 1, -32768, no_frame));
        dir_rows.push_back(row_typed(OP_SET, 0, 2, 0, no_frame));
        dir_rows.push_back(row_typed(OP_SET, 0, 3, -1,
                                     mk_frame(1'b0, 1'b1, 0, 16384, -16384, 0, -1)));
        // reversed slot at the widest limit
        dir_rows.push_back(row_cfg(CFG_LIMIT1, 32767));
        dir_rows.push_back(row_typed(OP_SET, 1, 0, 32767, no_frame));
        dir_rows.push_back(row_typed(OP_FLUSH, 1, 0, 0,
                                     mk_frame(1'b0, 1'b1, 1, -32767, 0, 0, 0)));
        dir_rows.push_back(row_cfg(CFG_LIMIT2, 0));
        dir_rows.push_back(row_typed(OP_SET, 2, 3, 12345, no_frame));
        dir_rows.push_back(row_typed(OP_ZERO, 2, 0, 0, mk_frame(1'b0, 1'b1, 2, 0, 0, 0, 0)));
        dir_rows.push_back(row_cfg(CFG_LIMIT0, 32767));
        dir_rows.push_back(row_cmd(OP_SET, 0, 0, -32768));
        // shrink group 0 to slot 1 while slot 0 is still pending
        dir_rows.push_back(row_cfg(CFG_MEMBER, 12'hFF2));
        dir_rows.push_back(row_cmd(OP_SET, 0, 1, 7));
        dir_rows.push_back(row_cmd(OP_SET, 0, 0, 3));
        dir_rows.push_back(row_cmd(OP_FLUSH, 0, 0, 0));
        dir_rows.push_back(row_cmd(OP_SET, 0, 1, 9));
        dir_rows.push_back(row_cmd(OP_SET, 1, 1, -20000));

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                settle_pipeline();
                cfg_write(dir_rows[k].cfg_idx, dir_rows[k].cfg_data);
            end else begin
                send_cmd(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < 8; p++) begin
            settle_pipeline();
            case (p)
                0: begin
                    cfg_write(CFG_MEMBER, 15'h0FFF);
                    cfg_write(CFG_REVERSE, 15'h0000);
                    for (int g = 0; g < GROUPS; g++)
                        cfg_write(CFG_LIMIT0 + CFG_IDX_W'(g), LIMIT_RST);
                end
                1: begin
                    cfg_write(CFG_MEMBER, 15'h0FFF);
                    cfg_write(CFG_REVERSE, 15'h0FFF);
                    for (int g = 0; g < GROUPS; g++)
                        cfg_write(CFG_LIMIT0 + CFG_IDX_W'(g), 15'h7FFF);
                end
                2: begin
                    cfg_write(CFG_MEMBER, CFG_W'($urandom_range(4095)));
                    cfg_write(CFG_REVERSE, CFG_W'($urandom_range(4095)));
                    for (int g = 0; g < GROUPS; g++)
                        cfg_write(CFG_LIMIT0 + CFG_IDX_W'(g), 15'h0000);
                end
                4: begin
                    cfg_write(CFG_MEMBER, 15'h0000);
                    cfg_write(CFG_REVERSE, CFG_W'($urandom_range(4095)));
                    for (int g = 0; g < GROUPS; g++)
                        cfg_write(CFG_LIMIT0 + CFG_IDX_W'(g), CFG_W'($urandom_range(32767)));
                end
                5: begin
                    cfg_write(CFG_MEMBER, 15'h08C1);
                    cfg_write(CFG_REVERSE, 15'h00F0);
                    cfg_write(CFG_LIMIT0, 15'd1);
                    cfg_write(CFG_LIMIT1, 15'h7FFF);
                    cfg_write(CFG_LIMIT2, CFG_W'($urandom_range(32767)));
                end
                default: begin
                    cfg_write(CFG_MEMBER, CFG_W'($urandom_range(4095)));
                    cfg_write(CFG_REVERSE, CFG_W'($urandom_range(4095)));
                    for (int g = 0; g < GROUPS; g++) begin
                        lim_pick = $urandom_range(32767);
                        cfg_write(CFG_LIMIT0 + CFG_IDX_W'(g), CFG_W'(lim_pick));
                    end
                end
            endcase

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase

            n_items = (p == 4) ? 40 : 158;
            for (int i = 0; i < n_items; i++) begin
                // hold the sender until the result queue has emptied
                if (p == 3 && i == n_items / 2) settle_pipeline();
                send_cmd(random_item(), 1'b0, no_frame);
            end
        end

        cmd_bus.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: grouped_command_collect_and_send.f
hdl/gccs_pkg.sv
hdl/gccs_cmd_if.sv
hdl/gccs_rsp_if.sv
hdl/gccs_front.sv
hdl/gccs_fifo.sv
hdl/gccs_back.sv
hdl/grouped_command_collect_and_send.sv
bench/grouped_command_collect_and_send_test.sv
